/* src/ssil_pkg.sv */
package ssil_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int COUNT_W  = 6;
  localparam int VALUE_W  = 32;

  typedef enum logic [2:0] {
    STATUS_INSERTED  = 3'd0,
    STATUS_DUPLICATE = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_FOUND     = 3'd3,
    STATUS_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_QUERY  = 1'b1
  } req_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic signed [VALUE_W-1:0] key;
    logic                      cmp_en;
    logic                      shift_en;
  } bcast_t;

endpackage

/* src/sorted_set_insert_lookup_core.sv */
// sorted set store: keeps up to CAPACITY distinct signed 32-bit values in
// ascending order in a row of cells, one value per cell
//
// input channel: in_valid / in_stall with req_type (0 insert, 1 query) and
// value; an item is taken at an edge where in_valid is high and in_stall low
// output channel: out_valid / out_stall with status and entry_count, one
// result item per input item, in order
//
// timing: an item is taken in IDLE, compared in every cell in CMP and
// committed in UPD, when out_valid rises; the next item is taken only after
// that commit, so the block does not take a new item before it is through
// with the last one. this comes from the compare-then-shift pass through the
// cell row, where each item needs the store as the previous item left it
//
// stall: a waiting result holds its fields; a new item may still be taken
// and compared, but it does not commit or touch the store until the waiting
// result is taken
//
// reset: the held count goes to zero and no result is pending; cell contents
// stay undefined, since only cells below the count are ever compared
module sorted_set_insert_lookup_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                req_type,
  input  logic signed [ssil_pkg::VALUE_W-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          status,
  output logic [ssil_pkg::COUNT_W-1:0]        entry_count
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_t;

  state_t                               state;
  logic                                 kind;
  logic signed [ssil_pkg::VALUE_W-1:0]  key;
  logic [ssil_pkg::COUNT_W-1:0]         count;

  ssil_pkg::bcast_t                     bc;
  ssil_pkg::status_t                    status_next;
  logic [ssil_pkg::COUNT_W-1:0]         count_next;

  logic signed [ssil_pkg::VALUE_W-1:0]  cell_value [ssil_pkg::CAPACITY];
  logic [ssil_pkg::CAPACITY-1:0]        less_v;
  logic [ssil_pkg::CAPACITY-1:0]        eq_v;

  logic present;
  logic commit;
  logic ins_ok;

  // a result can be committed when the output register is empty or draining
  assign commit   = !out_valid || !out_stall;
  assign present  = |eq_v;
  assign ins_ok   = (kind == ssil_pkg::REQ_INSERT) && !present &&
                    (count < ssil_pkg::COUNT_W'(ssil_pkg::CAPACITY));
  assign in_stall = (state != ST_IDLE);

  always_comb begin
    if (kind == ssil_pkg::REQ_QUERY) begin
      status_next = present ? ssil_pkg::STATUS_FOUND : ssil_pkg::STATUS_NOT_FOUND;
    end else if (present) begin
      status_next = ssil_pkg::STATUS_DUPLICATE;
    end else if (!ins_ok) begin
      status_next = ssil_pkg::STATUS_FULL;
    end else begin
      status_next = ssil_pkg::STATUS_INSERTED;
    end
    count_next = ins_ok ? count + 1'b1 : count;
  end

  // key goes to every cell; compare in CMP, shift on commit of an accepted insert
  always_comb begin
    bc.key      = key;
    bc.cmp_en   = (state == ST_CMP);
    bc.shift_en = (state == ST_UPD) && commit && ins_ok;
  end

  // cell row: a shift puts the key in the insert cell, higher cells move up one
  for (genvar i = 0; i < ssil_pkg::CAPACITY; i++) begin : g_cell
    logic signed [ssil_pkg::VALUE_W-1:0] left_value;
    logic                                left_less;

    if (i == 0) begin : g_head
      assign left_value = key;
      assign left_less  = 1'b1;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_less  = less_v[i-1];
    end

    ssil_cell u_cell (
      .clk        (clk),
      .bc         (bc),
      .idx        (ssil_pkg::IDX_W'(i)),
      .count      (count),
      .left_value (left_value),
      .left_less  (left_less),
      .value_q    (cell_value[i]),
      .less       (less_v[i]),
      .eq         (eq_v[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // a taken result empties the output unless a new one commits now
      if (out_valid && !out_stall && (state != ST_UPD)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            kind  <= req_type;
            key   <= value;
            state <= ST_CMP;
          end
        end
        ST_CMP: begin
          state <= ST_UPD;
        end
        ST_UPD: begin
          if (commit) begin
            count       <= count_next;
            status      <= status_next;
            entry_count <= count_next;
            out_valid   <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // held entries are ascending, so the less-than flags form a run from cell 0
  a_less_prefix: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> ((less_v & (less_v + 1'b1)) == '0))
    else $error("less-than flags not a prefix of the cell row");

  // distinct entries: at most one cell can match the key
  a_eq_single: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) |-> $onehot0(eq_v))
    else $error("more than one cell matches the key");

  // a committed insert grows the count by exactly one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    bc.shift_en |=> (count == $past(count) + 1'b1))
    else $error("insert did not advance the count by one");

  // the count never passes the capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPD) && commit |=>
      (count <= ssil_pkg::COUNT_W'(ssil_pkg::CAPACITY)))
    else $error("count beyond capacity");

endmodule

/* src/ssil_cell.sv */
module ssil_cell (
  input  logic                                 clk,
  input  ssil_pkg::bcast_t                     bc,
  input  logic [ssil_pkg::IDX_W-1:0]           idx,
  input  logic [ssil_pkg::COUNT_W-1:0]         count,
  input  logic signed [ssil_pkg::VALUE_W-1:0]  left_value,
  input  logic                                 left_less,
  output logic signed [ssil_pkg::VALUE_W-1:0]  value_q,
  output logic                                 less,
  output logic                                 eq
);

  logic occupied;

  assign occupied = ssil_pkg::COUNT_W'(idx) < count;

  always_ff @(posedge clk) begin
    if (bc.cmp_en) begin
      less <= occupied && (value_q < bc.key);
      eq   <= occupied && (value_q == bc.key);
    end
    // cells below the insert point keep their entry, the rest move up one
    if (bc.shift_en && !less) begin
      value_q <= left_less ? bc.key : left_value;
    end
  end

endmodule

/* test/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_CYCLES = 80;
  localparam int SETTLE_CYCLES = 12;
  localparam int TIMEOUT_NS = 1_000_000;
  localparam logic signed [ssil_pkg::VALUE_W-1:0] MIN_VALUE = 32'sh8000_0000;
  localparam logic signed [ssil_pkg::VALUE_W-1:0] MAX_VALUE = 32'sh7fff_ffff;

  // one predicted result item
  typedef struct {
    ssil_pkg::status_t               st;
    logic [ssil_pkg::COUNT_W-1:0]    cnt;
  } set_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic req_type = 1'b0;
  logic signed [ssil_pkg::VALUE_W-1:0] value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] status;
  logic [ssil_pkg::COUNT_W-1:0] entry_count;

  // predictor copy of the sorted store
  logic signed [ssil_pkg::VALUE_W-1:0] held_vals [ssil_pkg::CAPACITY];
  int held_n = 0;

  // results predicted for accepted items, oldest first
  set_result_t pending_results [$];

  int error_count = 0;
  int items_sent = 0;
  int inserts_sent = 0;
  int results_checked = 0;
  int in_stall_cycles = 0;
  int status_tally [5] = '{default: 0};

  // idle percentages for the sending and receiving sides
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // long receiver hold-off, requested by the tests and served by the receiver
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  sorted_set_insert_lookup_core uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .entry_count (entry_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d result items still pending", pending_results.size());
    $display("Some tests failed");
    $finish;
  end

  // receiver: random stalls, or a long counted hold-off when one is requested
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // checker: every taken result item against the oldest prediction
  always @(posedge clk) begin : check_results
    set_result_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result item status=%0d count=%0d with nothing pending",
                                  status, entry_count));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st)
          report_mismatch($sformatf("status %0d, expected %s (result %0d)",
                                    status, want.st.name(), results_checked));
        if (entry_count !== want.cnt)
          report_mismatch($sformatf("entry_count %0d, expected %0d (result %0d)",
                                    entry_count, want.cnt, results_checked));
      end
    end
  end

  // sorted insert / membership lookup on the predictor's own store
  function automatic void predict_request(input ssil_pkg::req_t kind,
                                          input logic signed [ssil_pkg::VALUE_W-1:0] v,
                                          output set_result_t res);
    int pos;
    int i;
    bit present;
    pos = 0;
    // first held entry not less than v
    while (pos < held_n && held_vals[pos] < v) pos++;
    present = (pos < held_n) && (held_vals[pos] == v);
    if (kind == ssil_pkg::REQ_QUERY) begin
      res.st = present ? ssil_pkg::STATUS_FOUND : ssil_pkg::STATUS_NOT_FOUND;
    end else if (present) begin
      // duplicate check wins over full
      res.st = ssil_pkg::STATUS_DUPLICATE;
    end else if (held_n >= ssil_pkg::CAPACITY) begin
      res.st = ssil_pkg::STATUS_FULL;
    end else begin
      // shift larger entries up one place
      for (i = held_n; i > pos; i--) held_vals[i] = held_vals[i-1];
      held_vals[pos] = v;
      held_n++;
      res.st = ssil_pkg::STATUS_INSERTED;
    end
    res.cnt = ssil_pkg::COUNT_W'(held_n);
    status_tally[int'(res.st)]++;
  endfunction

  // value mix: held entries, their neighbors, extremes, and plain random words
  function automatic logic signed [ssil_pkg::VALUE_W-1:0] pick_value();
    logic signed [ssil_pkg::VALUE_W-1:0] v;
    case ($urandom_range(9))
      0, 1, 2, 3: v = (held_n > 0) ? held_vals[$urandom_range(held_n - 1)] : $urandom;
      4: begin
        v = (held_n > 0) ? held_vals[$urandom_range(held_n - 1)] : '0;
        v = $urandom_range(1) ? v + 1 : v - 1;
      end
      5: begin
        case ($urandom_range(5))
          0: v = MIN_VALUE;
          1: v = MAX_VALUE;
          2: v = 0;
          3: v = -1;
          4: v = MIN_VALUE + 1;
          default: v = MAX_VALUE - 1;
        endcase
      end
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // offer one item, holding it until the block takes it, then predict its result
  task automatic send_request(input ssil_pkg::req_t kind,
                              input logic signed [ssil_pkg::VALUE_W-1:0] v);
    set_result_t res;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    value <= v;
    forever begin
      @(posedge clk);
      if (in_stall === 1'b0) break;
      in_stall_cycles++;
    end
    predict_request(kind, v, res);
    pending_results.push_back(res);
    items_sent++;
    if (kind == ssil_pkg::REQ_INSERT) inserts_sent++;
  endtask

  // sender pauses until every predicted result has come back
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // queries on an empty store all miss
  task automatic test_empty_store();
    send_request(ssil_pkg::REQ_QUERY, 0);
    send_request(ssil_pkg::REQ_QUERY, MIN_VALUE);
    send_request(ssil_pkg::REQ_QUERY, MAX_VALUE);
  endtask

  // inserts at the ends and in the middle, duplicates, hits and misses
  task automatic test_sorted_inserts();
    send_request(ssil_pkg::REQ_INSERT, 0);
    send_request(ssil_pkg::REQ_INSERT, MAX_VALUE);
    send_request(ssil_pkg::REQ_INSERT, MIN_VALUE);
    send_request(ssil_pkg::REQ_INSERT, -1);
    send_request(ssil_pkg::REQ_INSERT, 1);
    send_request(ssil_pkg::REQ_INSERT, 0);
    send_request(ssil_pkg::REQ_INSERT, MAX_VALUE);
    send_request(ssil_pkg::REQ_INSERT, -100);
    send_request(ssil_pkg::REQ_INSERT, 100);
    send_request(ssil_pkg::REQ_QUERY, MIN_VALUE);
    send_request(ssil_pkg::REQ_QUERY, MAX_VALUE);
    send_request(ssil_pkg::REQ_QUERY, -1);
    send_request(ssil_pkg::REQ_QUERY, 2);
    send_request(ssil_pkg::REQ_QUERY, MAX_VALUE - 1);
  endtask

  // random traffic, mostly inserts, until the store is full
  task automatic test_fill_store();
    while (held_n < ssil_pkg::CAPACITY)
      send_request($urandom_range(3) == 0 ? ssil_pkg::REQ_QUERY : ssil_pkg::REQ_INSERT,
                   pick_value());
  endtask

  // full store: duplicate still reported as duplicate, new value rejected
  task automatic test_full_store();
    send_request(ssil_pkg::REQ_INSERT, MAX_VALUE);
    send_request(ssil_pkg::REQ_INSERT, held_vals[ssil_pkg::CAPACITY/2]);
    send_request(ssil_pkg::REQ_INSERT,
                 held_vals[0] == MIN_VALUE ? MIN_VALUE + 1 : MIN_VALUE);
    send_request(ssil_pkg::REQ_QUERY, held_vals[ssil_pkg::CAPACITY-1]);
    send_request(ssil_pkg::REQ_QUERY, held_vals[3] + 1 == held_vals[4] ? held_vals[3] - 1
                                                                       : held_vals[3] + 1);
  endtask

  // receiver holds off while the sender keeps offering, so the input backs up
  task automatic test_receiver_hold();
    hold_requests++;
    repeat (40)
      send_request($urandom_range(1) ? ssil_pkg::REQ_QUERY : ssil_pkg::REQ_INSERT,
                   pick_value());
    wait_for_results();
  endtask

  task automatic test_random(input int n);
    repeat (n)
      send_request($urandom_range(1) ? ssil_pkg::REQ_QUERY : ssil_pkg::REQ_INSERT,
                   pick_value());
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // sender idles lightly, receiver heavily
    set_idle(28, 52);
    test_empty_store();
    test_sorted_inserts();
    test_fill_store();
    test_full_store();
    test_random(400);
    wait_for_results();

    // roles swapped
    set_idle(52, 28);
    test_random(400);

    // back to back, then a long receiver hold-off
    set_idle(0, 0);
    test_random(400);
    test_receiver_hold();
    test_random(40);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d items (%0d inserts, %0d queries), checked %0d results, %0d stall cycles",
             items_sent, inserts_sent, items_sent - inserts_sent, results_checked,
             in_stall_cycles);
    $display("statuses: inserted %0d, duplicate %0d, full %0d, found %0d, not found %0d",
             status_tally[0], status_tally[1], status_tally[2], status_tally[3],
             status_tally[4]);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
